// File: hw/rtl/smma_pkg.sv
// shared types and constants of the scaled matrix multiply-accumulate
`default_nettype none

package smma_pkg;

  localparam int unsigned MAX_DIM   = 4;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned COORD_W   = 2;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned DIM_W     = 3;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_LOAD_C  = 2'd2,
    OP_COMPUTE = 2'd3
  } op_e;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_M         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_N         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_P        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_PRODUCT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_EXISTING = 3'd4;

  localparam logic [DIM_W-1:0]          DIM_RESET            = 3'd4;
  localparam logic signed [VALUE_W-1:0] SCALE_PRODUCT_RESET  = 32'sd65536;
  localparam logic signed [VALUE_W-1:0] SCALE_EXISTING_RESET = 32'sd0;

endpackage

`default_nettype wire

// File: hw/rtl/scaled_matrix_multiply_accumulate.sv
// top level: C = u*C + v*A*B over small stored matrices, one shared multiplier
//
// input channel (in_valid_i/in_ready_o) carries op, row, col and value.
// a load request writes one element of A, B or C; loads can follow each other
// every cycle while no compute request is in progress and give no result.
// a compute request walks C in column-major order and sends one result
// request per element on the output channel (out_valid_o/out_ready_i),
// with last_o set on the final one.
// each element runs inner steps (store read, multiply, accumulate) on the single
// 32x32 multiplier, then saturate, v scaling, u scaling and write-back.
// in_ready_o is high only while no compute request is in progress.
// a stalled receiver holds the result in the output register and the
// sequencer waits; nothing is dropped.
// configuration writes (cfg_valid_i/cfg_ready_o) are always taken; indexes
// beyond the register list are ignored.
// reset restores the dimension and scale registers; the stores are not
// cleared and must be loaded before use.
`default_nettype none

module scaled_matrix_multiply_accumulate #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire  [smma_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  wire  [smma_pkg::VALUE_W-1:0]            cfg_data_i,
  input  wire                                     in_valid_i,
  output logic                                    in_ready_o,
  input  wire  [smma_pkg::OP_W-1:0]               op_i,
  input  wire  [smma_pkg::COORD_W-1:0]            row_i,
  input  wire  [smma_pkg::COORD_W-1:0]            col_i,
  input  wire  signed [smma_pkg::VALUE_W-1:0]     value_i,
  output logic                                    out_valid_o,
  input  wire                                     out_ready_i,
  output logic [smma_pkg::COORD_W-1:0]            out_row_o,
  output logic [smma_pkg::COORD_W-1:0]            out_col_o,
  output logic signed [smma_pkg::VALUE_W-1:0]     out_value_o,
  output logic                                    last_o
);
  import smma_pkg::*;

  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_ACC  = 4'd3;
  localparam logic [3:0] S_SAT  = 4'd4;
  localparam logic [3:0] S_PART = 4'd5;
  localparam logic [3:0] S_OLD  = 4'd6;
  localparam logic [3:0] S_RES  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  // configuration
  logic [DIM_W-1:0]          rows_m_q, cols_n_q, inner_p_q;
  logic signed [VALUE_W-1:0] scale_product_q, scale_existing_q;

  // sequencer
  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [CNT_W-1:0] last_i, last_j, last_k;

  // datapath
  logic signed [VALUE_W-1:0]   a_rd_q, b_rd_q, c_rd_q, ab_q;
  logic signed [2*VALUE_W-1:0] prod_q, acc_q, part_q;
  logic signed [VALUE_W-1:0]   mul_a, mul_b;
  logic signed [2*VALUE_W-1:0] prod_d, prod_sh, acc_d;
  logic signed [2*VALUE_W:0]   acc_sum, res_sum;
  logic signed [VALUE_W-1:0]   ab_d, res_d;

  // stores
  logic [VALUE_W-1:0] a_mem [DEPTH];
  logic [VALUE_W-1:0] b_mem [DEPTH];
  logic [VALUE_W-1:0] c_mem [DEPTH];
  logic [ADDR_W-1:0]  ld_addr, a_raddr, b_raddr, ij_addr, c_waddr;
  logic [VALUE_W-1:0] c_wdata;
  logic               ld_ok, in_acc, a_we, b_we, c_we;

  // output register
  logic                      out_valid_q;
  logic [COORD_W-1:0]        out_row_q, out_col_q;
  logic signed [VALUE_W-1:0] out_value_q;
  logic                      last_q;

  // zero acts as one, above MAX_DIM acts as MAX_DIM
  function automatic logic [CNT_W-1:0] last_idx(input logic [DIM_W-1:0] r);
    logic [CNT_W-1:0] v;
    if (r == '0) begin
      v = '0;
    end else if (32'(r) > MAX_DIM) begin
      v = CNT_W'(MAX_DIM - 1);
    end else begin
      v = CNT_W'(32'(r) - 32'd1);
    end
    return v;
  endfunction

  assign last_i = last_idx(rows_m_q);
  assign last_j = last_idx(cols_n_q);
  assign last_k = last_idx(inner_p_q);

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_m_q         <= DIM_RESET;
      cols_n_q         <= DIM_RESET;
      inner_p_q        <= DIM_RESET;
      scale_product_q  <= SCALE_PRODUCT_RESET;
      scale_existing_q <= SCALE_EXISTING_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ROWS_M:         rows_m_q         <= cfg_data_i[DIM_W-1:0];
        CFG_COLS_N:         cols_n_q         <= cfg_data_i[DIM_W-1:0];
        CFG_INNER_P:        inner_p_q        <= cfg_data_i[DIM_W-1:0];
        CFG_SCALE_PRODUCT:  scale_product_q  <= cfg_data_i;
        CFG_SCALE_EXISTING: scale_existing_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // store addressing
  assign ld_ok   = (32'(row_i) < MAX_DIM) && (32'(col_i) < MAX_DIM);
  assign ld_addr = ADDR_W'(32'(row_i) * MAX_DIM + 32'(col_i));
  assign a_raddr = ADDR_W'(32'(i_q) * MAX_DIM + 32'(k_q));
  assign b_raddr = ADDR_W'(32'(k_q) * MAX_DIM + 32'(j_q));
  assign ij_addr = ADDR_W'(32'(i_q) * MAX_DIM + 32'(j_q));

  assign a_we = in_acc && ld_ok && (op_i == OP_LOAD_A);
  assign b_we = in_acc && ld_ok && (op_i == OP_LOAD_B);

  always_comb begin
    c_we    = 1'b0;
    c_waddr = ld_addr;
    c_wdata = value_i;
    if (state_q == S_RES) begin
      c_we    = 1'b1;
      c_waddr = ij_addr;
      c_wdata = res_d;
    end else if (in_acc && ld_ok && (op_i == OP_LOAD_C)) begin
      c_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[ld_addr] <= value_i;
    end
    a_rd_q <= a_mem[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      b_mem[ld_addr] <= value_i;
    end
    b_rd_q <= b_mem[b_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      c_mem[c_waddr] <= c_wdata;
    end
    c_rd_q <= c_mem[ij_addr];
  end

  // shared multiplier operand select
  always_comb begin
    unique case (state_q)
      S_PART: begin
        mul_a = scale_product_q;
        mul_b = ab_q;
      end
      S_OLD: begin
        mul_a = scale_existing_q;
        mul_b = c_rd_q;
      end
      default: begin
        mul_a = a_rd_q;
        mul_b = b_rd_q;
      end
    endcase
  end

  assign prod_d  = mul_a * mul_b;
  assign prod_sh = prod_q >>> FRAC_BITS;

  // saturating 64-bit accumulate
  assign acc_sum = {acc_q[2*VALUE_W-1], acc_q} + {prod_sh[2*VALUE_W-1], prod_sh};
  always_comb begin
    if (acc_sum[2*VALUE_W] != acc_sum[2*VALUE_W-1]) begin
      acc_d = acc_sum[2*VALUE_W] ? {1'b1, {(2*VALUE_W-1){1'b0}}}
                                 : {1'b0, {(2*VALUE_W-1){1'b1}}};
    end else begin
      acc_d = acc_sum[2*VALUE_W-1:0];
    end
  end

  always_comb begin
    if (acc_q[2*VALUE_W-1:VALUE_W-1] == '0 || acc_q[2*VALUE_W-1:VALUE_W-1] == '1) begin
      ab_d = acc_q[VALUE_W-1:0];
    end else if (acc_q[2*VALUE_W-1]) begin
      ab_d = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      ab_d = {1'b0, {(VALUE_W-1){1'b1}}};
    end
  end

  // old term is zero when u is zero; the sum cannot leave 65 bits
  always_comb begin
    if (scale_existing_q != '0) begin
      res_sum = {prod_sh[2*VALUE_W-1], prod_sh} + {part_q[2*VALUE_W-1], part_q};
    end else begin
      res_sum = {part_q[2*VALUE_W-1], part_q};
    end
    if (res_sum[2*VALUE_W:VALUE_W-1] == '0 || res_sum[2*VALUE_W:VALUE_W-1] == '1) begin
      res_d = res_sum[VALUE_W-1:0];
    end else if (res_sum[2*VALUE_W]) begin
      res_d = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      res_d = {1'b0, {(VALUE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL || state_q == S_PART || state_q == S_OLD) begin
      prod_q <= prod_d;
    end
    if (state_q == S_RD && k_q == '0) begin
      acc_q <= '0;
    end else if (state_q == S_ACC) begin
      acc_q <= acc_d;
    end
    if (state_q == S_SAT) begin
      ab_q <= ab_d;
    end
    if (state_q == S_OLD) begin
      part_q <= prod_sh;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && op_i == OP_COMPUTE) begin
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
          state_d = S_RD;
        end
      end
      S_RD:   state_d = S_MUL;
      S_MUL:  state_d = S_ACC;
      S_ACC: begin
        if (k_q == last_k) begin
          k_d     = '0;
          state_d = S_SAT;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_SAT:  state_d = S_PART;
      S_PART: state_d = S_OLD;
      S_OLD:  state_d = S_RES;
      S_RES:  state_d = S_OUT;
      S_OUT: begin
        if (out_ready_i) begin
          if (i_q == last_i) begin
            i_d = '0;
            if (j_q == last_j) begin
              state_d = S_IDLE;
            end else begin
              j_d     = j_q + 1'b1;
              state_d = S_RD;
            end
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_RES) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RES) begin
      out_row_q   <= COORD_W'(32'(i_q));
      out_col_q   <= COORD_W'(32'(j_q));
      out_value_q <= res_d;
      last_q      <= (i_q == last_i) && (j_q == last_j);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// File: tb/scaled_matrix_multiply_accumulate_test.sv
// self-checking testbench of the scaled matrix multiply-accumulate block
module scaled_matrix_multiply_accumulate_test;
  import smma_pkg::*;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned ITEM_GOAL  = 480;
  localparam int unsigned STALL_LIMIT = 2000;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] ONE_Q     = 32'sh0001_0000;

  typedef struct {
    op_e                        op;
    logic [COORD_W-1:0]         row;
    logic [COORD_W-1:0]         col;
    logic signed [VALUE_W-1:0]  value;
  } request_t;

  typedef struct {
    logic [COORD_W-1:0]         row;
    logic [COORD_W-1:0]         col;
    logic signed [VALUE_W-1:0]  value;
    logic                       last;
  } c_elem_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [CFG_IDX_W-1:0]        cfg_index_i = '0;
  logic [VALUE_W-1:0]          cfg_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic [OP_W-1:0]             op_i = '0;
  logic [COORD_W-1:0]          row_i = '0;
  logic [COORD_W-1:0]          col_i = '0;
  logic signed [VALUE_W-1:0]   value_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [COORD_W-1:0]          out_row_o;
  logic [COORD_W-1:0]          out_col_o;
  logic signed [VALUE_W-1:0]   out_value_o;
  logic                        last_o;

  scaled_matrix_multiply_accumulate u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .out_value_o (out_value_o),
    .last_o      (last_o)
  );

  // predictor state: stores and register mirror
  logic signed [VALUE_W-1:0] a_elems [MAX_DIM*MAX_DIM];
  logic signed [VALUE_W-1:0] b_elems [MAX_DIM*MAX_DIM];
  logic signed [VALUE_W-1:0] c_elems [MAX_DIM*MAX_DIM];
  logic [DIM_W-1:0]          rows_reg = DIM_RESET;
  logic [DIM_W-1:0]          cols_reg = DIM_RESET;
  logic [DIM_W-1:0]          inner_reg = DIM_RESET;
  logic signed [VALUE_W-1:0] v_scale = SCALE_PRODUCT_RESET;
  logic signed [VALUE_W-1:0] u_scale = SCALE_EXISTING_RESET;

  request_t    request_q [$];
  c_elem_t     c_elem_due [$];
  request_t    next_req;
  c_elem_t     due_head;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned sent_items = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  bit          in_took = 1'b0;
  bit          out_took = 1'b0;
  bit          cfg_took = 1'b0;
  bit          quiet_phase = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] small_q;
    small_q = $urandom_range(0, 32'h0008_0000);
    case ($urandom_range(0, 11)) inside
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      2:       return $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
      3:       return ONE_Q;
      [4:6]:   return small_q - 32'h0004_0000;   // within +-4.0
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 3) return '0;
    if (r < 5) return DIM_W'($urandom_range(5, 7));
    return DIM_W'($urandom_range(1, MAX_DIM));
  endfunction

  // out-of-range dimension registers clamp to 1..MAX_DIM
  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_DIM) return MAX_DIM;
    return 32'(r);
  endfunction

  function automatic longint q_mul(input logic signed [VALUE_W-1:0] a,
                                   input logic signed [VALUE_W-1:0] b);
    return (longint'(a) * longint'(b)) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [VALUE_W-1:0] clamp32(input longint x);
    if (x > 64'sd2147483647) return VALUE_MAX;
    if (x < -64'sd2147483648) return VALUE_MIN;
    return x[VALUE_W-1:0];
  endfunction

  // updates C in place and queues every element in column-major order
  task automatic predict_gemm();
    int unsigned m, n, p, idx;
    longint      acc, part, prior;
    c_elem_t     e;
    m = eff_dim(rows_reg);
    n = eff_dim(cols_reg);
    p = eff_dim(inner_reg);
    for (int unsigned j = 0; j < n; j++) begin
      for (int unsigned i = 0; i < m; i++) begin
        acc = 0;
        for (int unsigned k = 0; k < p; k++) begin
          acc += q_mul(a_elems[i*MAX_DIM+k], b_elems[k*MAX_DIM+j]);
        end
        part  = q_mul(v_scale, clamp32(acc));
        idx   = i*MAX_DIM + j;
        // zero u means old C is not read at all
        prior = (u_scale != 0) ? q_mul(u_scale, c_elems[idx]) : 0;
        c_elems[idx] = clamp32(prior + part);
        e.row   = i[COORD_W-1:0];
        e.col   = j[COORD_W-1:0];
        e.value = c_elems[idx];
        e.last  = (i == m-1) && (j == n-1);
        c_elem_due.push_back(e);
      end
    end
  endtask

  task automatic apply_request(input request_t r);
    int unsigned idx;
    idx = r.row*MAX_DIM + r.col;
    case (r.op)
      OP_LOAD_A:  a_elems[idx] = r.value;
      OP_LOAD_B:  b_elems[idx] = r.value;
      OP_LOAD_C:  c_elems[idx] = r.value;
      OP_COMPUTE: predict_gemm();
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  // monitor: sample handshakes at the rising edge, check and predict
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_took  = in_valid_i && in_ready_o;
      out_took = out_valid_o && out_ready_i;
      cfg_took = cfg_valid_i && cfg_ready_o;
      if (out_took) begin
        if (c_elem_due.size() == 0) begin
          flag_mismatch("unexpected result, value", out_value_o, 0);
        end else begin
          due_head = c_elem_due.pop_front();
          if (out_row_o !== due_head.row) flag_mismatch("out_row", out_row_o, due_head.row);
          if (out_col_o !== due_head.col) flag_mismatch("out_col", out_col_o, due_head.col);
          if (out_value_o !== due_head.value)
            flag_mismatch("out_value", out_value_o, due_head.value);
          if (last_o !== due_head.last) flag_mismatch("last", last_o, due_head.last);
        end
      end
      if (cfg_took) begin
        case (cfg_index_i)
          CFG_ROWS_M:         rows_reg  = cfg_data_i[DIM_W-1:0];
          CFG_COLS_N:         cols_reg  = cfg_data_i[DIM_W-1:0];
          CFG_INNER_P:        inner_reg = cfg_data_i[DIM_W-1:0];
          CFG_SCALE_PRODUCT:  v_scale   = cfg_data_i;
          CFG_SCALE_EXISTING: u_scale   = cfg_data_i;
          default: ;
        endcase
      end
      if (in_took) begin
        next_req.op    = op_e'(op_i);
        next_req.row   = row_i;
        next_req.col   = col_i;
        next_req.value = value_i;
        apply_request(next_req);
      end
      if (in_took || out_took || cfg_took) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_took) begin
        // hold until taken
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (request_q.size() != 0) begin
        next_req    = request_q.pop_front();
        in_valid_i <= 1'b1;
        op_i       <= next_req.op;
        row_i      <= next_req.row;
        col_i      <= next_req.col;
        value_i    <= next_req.value;
        send_gap    = quiet_phase ? 0 : pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver with random back-pressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (!quiet_phase && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  initial begin
    wait (rst_ni);
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("watchdog: no progress, %0d results outstanding", c_elem_due.size());
    $display("end of test: mismatches");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_load(input op_e op, input int row, input int col,
                            input logic signed [VALUE_W-1:0] value);
    request_t r;
    r.op    = op;
    r.row   = row[COORD_W-1:0];
    r.col   = col[COORD_W-1:0];
    r.value = value;
    request_q.push_back(r);
    sent_items++;
  endtask

  // index and value fields are don't-care on compute, so randomise them
  task automatic queue_gemm();
    queue_load(OP_COMPUTE, $urandom_range(0, 3), $urandom_range(0, 3), $urandom());
  endtask

  // wait until the block has drained everything, loads included
  task automatic settle();
    do @(posedge clk_i);
    while (request_q.size() != 0 || in_valid_i || c_elem_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int unsigned blocks;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // every store entry written before any compute can read it
    write_reg(CFG_ROWS_M, 4);
    write_reg(CFG_COLS_N, 4);
    write_reg(CFG_INNER_P, 4);
    write_reg(CFG_SCALE_PRODUCT, ONE_Q);
    write_reg(CFG_SCALE_EXISTING, 0);
    for (int r = 0; r < MAX_DIM; r++) begin
      for (int c = 0; c < MAX_DIM; c++) begin
        queue_load(OP_LOAD_A, r, c, pick_value());
        queue_load(OP_LOAD_B, r, c, pick_value());
        queue_load(OP_LOAD_C, r, c, pick_value());
      end
    end
    queue_gemm();
    settle();

    // saturation both ways, extreme scales
    write_reg(CFG_SCALE_PRODUCT, VALUE_MAX);
    write_reg(CFG_SCALE_EXISTING, VALUE_MIN);
    for (int k = 0; k < MAX_DIM; k++) begin
      queue_load(OP_LOAD_A, 0, k, VALUE_MAX);
      queue_load(OP_LOAD_A, 1, k, VALUE_MIN);
      queue_load(OP_LOAD_B, k, 0, VALUE_MAX);
    end
    queue_load(OP_LOAD_C, 0, 0, VALUE_MIN);
    queue_load(OP_LOAD_C, 3, 3, -32'sd1);
    queue_gemm();
    settle();

    // dimension registers of zero and above the maximum
    write_reg(CFG_ROWS_M, 0);
    write_reg(CFG_COLS_N, 7);
    write_reg(CFG_INNER_P, 0);
    write_reg(CFG_SCALE_PRODUCT, VALUE_MIN);
    write_reg(CFG_SCALE_EXISTING, ONE_Q);
    queue_gemm();
    settle();
    write_reg(CFG_ROWS_M, 7);
    write_reg(CFG_COLS_N, 0);
    write_reg(CFG_INNER_P, 7);
    write_reg(CFG_SCALE_EXISTING, -32'sd1);
    write_reg(CFG_SCALE_EXISTING + 3'd1 + 3'($urandom_range(0, 2)), $urandom());
    queue_gemm();
    settle();

    // random phases: loads with random content in runs closed by a compute, at times one more load after the last run
    while (sent_items < ITEM_GOAL) begin
      quiet_phase = ($urandom_range(0, 4) == 0);
      write_reg(CFG_ROWS_M, pick_dim());
      write_reg(CFG_COLS_N, pick_dim());
      write_reg(CFG_INNER_P, pick_dim());
      write_reg(CFG_SCALE_PRODUCT, pick_value());
      write_reg(CFG_SCALE_EXISTING, ($urandom_range(0, 9) < 3) ? 32'sd0 : pick_value());
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_SCALE_EXISTING + 3'd1 + 3'($urandom_range(0, 2)), $urandom());
      blocks = $urandom_range(1, 3);
      for (int b = 0; b < blocks; b++) begin
        repeat ($urandom_range(0, 12))
          queue_load(op_e'($urandom_range(0, 2)), $urandom_range(0, 3),
                     $urandom_range(0, 3), pick_value());
        queue_gemm();
      end
      if ($urandom_range(0, 9) == 0)
        queue_load(op_e'($urandom_range(0, 2)), $urandom_range(0, 3),
                   $urandom_range(0, 3), pick_value());
      settle();
    end

    quiet_phase = 1'b0;
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/smma_pkg.sv
hw/rtl/scaled_matrix_multiply_accumulate.sv
tb/scaled_matrix_multiply_accumulate_test.sv
